FILE: rtl/tdcp_pkg.sv
// Shared types and constants for the TLV display command parser.
// No dependencies; every other rtl file but tdcp_ram refers to this package by scoped name.

package tdcp_pkg;

	// Text store sizing
	localparam int TEXT_MAX = 36;
	localparam int ADDR_W   = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
	localparam int CNT_W    = $clog2(TEXT_MAX + 1);

	// Result field widths
	localparam int KIND_W  = 4;
	localparam int VALUE_W = 24;
	localparam int IDX_W   = 6;

	// Command queue between parser and emitter (power of two)
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_PROGRESS       = 4'd0;
	localparam logic [KIND_W-1:0] KIND_BAR_COLOUR     = 4'd1;
	localparam logic [KIND_W-1:0] KIND_PERCENT_COLOUR = 4'd2;
	localparam logic [KIND_W-1:0] KIND_TOP_HDR        = 4'd3;
	localparam logic [KIND_W-1:0] KIND_BOTTOM_HDR     = 4'd4;
	localparam logic [KIND_W-1:0] KIND_TEXT_CHAR      = 4'd5;
	localparam logic [KIND_W-1:0] KIND_TOP_COLOUR     = 4'd6;
	localparam logic [KIND_W-1:0] KIND_BOTTOM_COLOUR  = 4'd7;
	localparam logic [KIND_W-1:0] KIND_BAD_LENGTH     = 4'd8;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN_TYPE   = 4'd9;
	localparam logic [KIND_W-1:0] KIND_TRUNCATED      = 4'd10;
	localparam logic [KIND_W-1:0] KIND_DANGLING       = 4'd11;

	// One queued command: the record or status result, text headers expand later
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
	} cmd_t;

endpackage

FILE: rtl/tdcp_if.sv
// Channel interfaces for the TLV display command parser: packet bytes in, results out.
// Depends on tdcp_pkg for field widths.

interface tdcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       end_of_packet;

	modport source(output valid, output payload_byte, output end_of_packet, input ready);
	modport sink(input valid, input payload_byte, input end_of_packet, output ready);
endinterface

interface tdcp_out_if;
	logic                         valid;
	logic                         ready;
	logic [tdcp_pkg::KIND_W-1:0]  kind;
	logic [tdcp_pkg::VALUE_W-1:0] value;
	logic [tdcp_pkg::IDX_W-1:0]   char_index;
	logic                         last;

	modport source(output valid, output kind, output value, output char_index, output last,
		input ready);
	modport sink(input valid, input kind, input value, input char_index, input last,
		output ready);
endinterface

FILE: rtl/tdcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module tdcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/tdcp_cmd_fifo.sv
// Short command queue between the byte parser and the result emitter.
// Depends on tdcp_pkg for cmd_t and queue sizing.

module tdcp_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tdcp_pkg::cmd_t push_cmd,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output tdcp_pkg::cmd_t head
);

	tdcp_pkg::cmd_t                    entry_q [tdcp_pkg::CMDQ_DEPTH];
	logic [tdcp_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [tdcp_pkg::CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [tdcp_pkg::CMDQ_CNT_W-1:0]   count_q;

	assign not_full  = count_q != tdcp_pkg::CMDQ_CNT_W'(tdcp_pkg::CMDQ_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/tdcp_front.sv
// Byte parser: walks type, length and value bytes, fills the text store and
// queues one command per completed record or packet error. Depends on tdcp_pkg, tdcp_if.

module tdcp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	tdcp_in_if.sink                       pkt,
	output logic                          push,
	output tdcp_pkg::cmd_t                push_cmd,
	input  logic                          q_not_full,
	input  logic                          txt_done,
	output logic                          ram_we,
	output logic [tdcp_pkg::ADDR_W-1:0]   ram_waddr,
	output logic [7:0]                    ram_wdata
);

	// Parse phases
	localparam logic [1:0] PH_TYPE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_VAL  = 2'd2;

	// Record type codes
	localparam logic [7:0] TYPE_PROGRESS      = 8'h01;
	localparam logic [7:0] TYPE_BAR           = 8'h02;
	localparam logic [7:0] TYPE_PERCENT       = 8'h03;
	localparam logic [7:0] TYPE_TOP_TEXT      = 8'h04;
	localparam logic [7:0] TYPE_TOP_COLOUR    = 8'h05;
	localparam logic [7:0] TYPE_BOTTOM_TEXT   = 8'h06;
	localparam logic [7:0] TYPE_BOTTOM_COLOUR = 8'h07;

	logic [1:0]  phase_q, phase_nxt;
	logic [7:0]  type_q, type_nxt;
	logic [7:0]  len_q, len_nxt;
	logic [7:0]  seen_q, seen_nxt;
	logic [23:0] acc_q, acc_nxt;
	logic        txt_busy_q;
	logic        accept;
	logic        emit;
	logic        write_txt;
	tdcp_pkg::cmd_t cmd;

	// Check a finished record and build its command
	function automatic tdcp_pkg::cmd_t complete(logic [7:0] t, logic [7:0] len,
		logic [23:0] rgb);
		tdcp_pkg::cmd_t c;
		logic [7:0]     cnt;
		c.kind  = tdcp_pkg::KIND_UNKNOWN_TYPE;
		c.value = {16'd0, t};
		cnt     = (len < 8'(tdcp_pkg::TEXT_MAX)) ? len : 8'(tdcp_pkg::TEXT_MAX);
		case (t)
			TYPE_PROGRESS: begin
				if (len != 8'd1) begin
					c.kind  = tdcp_pkg::KIND_BAD_LENGTH;
					c.value = {16'd0, len};
				end else begin
					c.kind  = tdcp_pkg::KIND_PROGRESS;
					c.value = {16'd0, rgb[7:0]};
				end
			end
			TYPE_BAR, TYPE_PERCENT, TYPE_TOP_COLOUR, TYPE_BOTTOM_COLOUR: begin
				if (len != 8'd3) begin
					c.kind  = tdcp_pkg::KIND_BAD_LENGTH;
					c.value = {16'd0, len};
				end else begin
					c.value = rgb;
					case (t)
						TYPE_BAR:        c.kind = tdcp_pkg::KIND_BAR_COLOUR;
						TYPE_PERCENT:    c.kind = tdcp_pkg::KIND_PERCENT_COLOUR;
						TYPE_TOP_COLOUR: c.kind = tdcp_pkg::KIND_TOP_COLOUR;
						default:         c.kind = tdcp_pkg::KIND_BOTTOM_COLOUR;
					endcase
				end
			end
			TYPE_TOP_TEXT: begin
				c.kind  = tdcp_pkg::KIND_TOP_HDR;
				c.value = {16'd0, cnt};
			end
			TYPE_BOTTOM_TEXT: begin
				c.kind  = tdcp_pkg::KIND_BOTTOM_HDR;
				c.value = {16'd0, cnt};
			end
			default: begin
				c.kind  = tdcp_pkg::KIND_UNKNOWN_TYPE;
				c.value = {16'd0, t};
			end
		endcase
		return c;
	endfunction

	// Hold off bytes while the command queue is full or a text job still reads the store
	assign pkt.ready = q_not_full && !txt_busy_q;
	assign accept    = pkt.valid && pkt.ready;

	// Next-state and command for the byte on the port
	always_comb begin
		phase_nxt = phase_q;
		type_nxt  = type_q;
		len_nxt   = len_q;
		seen_nxt  = seen_q;
		acc_nxt   = acc_q;
		emit      = 1'b0;
		write_txt = 1'b0;
		cmd       = '0;
		unique case (phase_q)
			PH_LEN: begin
				len_nxt  = pkt.payload_byte;
				seen_nxt = '0;
				acc_nxt  = '0;
				if (pkt.payload_byte == 8'd0) begin
					phase_nxt = PH_TYPE;
					emit      = 1'b1;
					cmd       = complete(type_q, pkt.payload_byte, 24'd0);
				end else if (pkt.end_of_packet) begin
					phase_nxt = PH_TYPE;
					emit      = 1'b1;
					cmd.kind  = tdcp_pkg::KIND_TRUNCATED;
					cmd.value = '0;
				end else begin
					phase_nxt = PH_VAL;
				end
			end
			PH_VAL: begin
				if (seen_q < 8'd3) begin
					acc_nxt = {acc_q[15:0], pkt.payload_byte};
				end
				write_txt = seen_q < 8'(tdcp_pkg::TEXT_MAX);
				seen_nxt  = seen_q + 8'd1;
				if (seen_nxt >= len_q) begin
					phase_nxt = PH_TYPE;
					emit      = 1'b1;
					cmd       = complete(type_q, len_q, acc_nxt);
				end else if (pkt.end_of_packet) begin
					phase_nxt = PH_TYPE;
					emit      = 1'b1;
					cmd.kind  = tdcp_pkg::KIND_TRUNCATED;
					cmd.value = {16'd0, seen_nxt};
				end
			end
			default: begin
				type_nxt = pkt.payload_byte;
				if (pkt.end_of_packet) begin
					phase_nxt = PH_TYPE;
					emit      = 1'b1;
					cmd.kind  = tdcp_pkg::KIND_DANGLING;
					cmd.value = 24'd1;
				end else begin
					phase_nxt = PH_LEN;
				end
			end
		endcase
	end

	assign push      = accept && emit;
	assign push_cmd  = cmd;
	assign ram_we    = accept && write_txt;
	assign ram_waddr = seen_q[tdcp_pkg::ADDR_W-1:0];
	assign ram_wdata = pkt.payload_byte;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			type_q     <= '0;
			len_q      <= '0;
			seen_q     <= '0;
			acc_q      <= '0;
			txt_busy_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_nxt;
				type_q  <= type_nxt;
				len_q   <= len_nxt;
				seen_q  <= seen_nxt;
				acc_q   <= acc_nxt;
			end
			// Busy from queuing a text header until its last char, or an empty header, is loaded for output
			if (push && (cmd.kind == tdcp_pkg::KIND_TOP_HDR ||
				cmd.kind == tdcp_pkg::KIND_BOTTOM_HDR)) begin
				txt_busy_q <= 1'b1;
			end else if (txt_done) begin
				txt_busy_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/tdcp_back.sv
// Result emitter: pops queued commands, drives the output register and expands
// text headers into one char per result from the text store. Depends on tdcp_pkg, tdcp_if.

module tdcp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  tdcp_pkg::cmd_t                q_head,
	output logic                          q_pop,
	output logic                          ram_re,
	output logic [tdcp_pkg::ADDR_W-1:0]   ram_raddr,
	input  logic [7:0]                    ram_rdata,
	output logic                          txt_done,
	tdcp_out_if.source                    res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HDR  = 2'd1;
	localparam logic [1:0] ST_CHR  = 2'd2;

	logic [1:0]                      st_q, st_nxt;
	tdcp_pkg::cmd_t                  cmd_q;
	logic [tdcp_pkg::ADDR_W-1:0]     idx_q, idx_nxt;
	logic                            res_valid_q;
	logic [tdcp_pkg::KIND_W-1:0]     kind_q, kind_nxt;
	logic [tdcp_pkg::VALUE_W-1:0]    value_q, value_nxt;
	logic [tdcp_pkg::IDX_W-1:0]      cidx_q, cidx_nxt;
	logic                            last_q, last_nxt;
	logic                            load;
	logic                            emit;
	logic                            is_text;
	logic                            last_char;
	logic [tdcp_pkg::CNT_W-1:0]      cnt;

	assign load      = !res_valid_q || res.ready;
	assign cnt       = cmd_q.value[tdcp_pkg::CNT_W-1:0];
	assign is_text   = cmd_q.kind == tdcp_pkg::KIND_TOP_HDR ||
		cmd_q.kind == tdcp_pkg::KIND_BOTTOM_HDR;
	assign last_char = (tdcp_pkg::CNT_W'(idx_q) + 1'b1) == cnt;

	// Sequencer: header first, then chars one per cycle while the output register can load
	always_comb begin
		st_nxt    = st_q;
		idx_nxt   = idx_q;
		q_pop     = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		txt_done  = 1'b0;
		emit      = 1'b0;
		kind_nxt  = cmd_q.kind;
		value_nxt = cmd_q.value;
		cidx_nxt  = '0;
		last_nxt  = 1'b1;
		unique case (st_q)
			ST_HDR: begin
				if (load) begin
					emit = 1'b1;
					if (is_text && cnt != '0) begin
						last_nxt  = 1'b0;
						ram_re    = 1'b1;
						ram_raddr = '0;
						idx_nxt   = '0;
						st_nxt    = ST_CHR;
					end else begin
						txt_done = is_text;
						st_nxt   = ST_IDLE;
					end
				end
			end
			ST_CHR: begin
				kind_nxt  = tdcp_pkg::KIND_TEXT_CHAR;
				value_nxt = {16'd0, ram_rdata};
				cidx_nxt  = tdcp_pkg::IDX_W'(idx_q);
				last_nxt  = last_char;
				if (load) begin
					emit = 1'b1;
					if (last_char) begin
						txt_done = 1'b1;
						st_nxt   = ST_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + 1'b1;
						idx_nxt   = idx_q + 1'b1;
					end
				end
			end
			default: begin
				if (q_not_empty) begin
					q_pop  = 1'b1;
					st_nxt = ST_HDR;
				end
			end
		endcase
	end

	// Command hold register and output register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (load && emit) begin
			kind_q  <= kind_nxt;
			value_q <= value_nxt;
			cidx_q  <= cidx_nxt;
			last_q  <= last_nxt;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q  <= st_nxt;
			idx_q <= idx_nxt;
			if (load) begin
				res_valid_q <= emit;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.kind       = kind_q;
	assign res.value      = value_q;
	assign res.char_index = cidx_q;
	assign res.last       = last_q;

endmodule

FILE: rtl/tlv_display_command_parser.sv
// Top level of the TLV display command parser.
// Depends on tdcp_pkg, tdcp_if, tdcp_ram, tdcp_cmd_fifo, tdcp_front, tdcp_back.

// Packet bytes come in on pkt, one transfer per byte. A completed record or a
// packet error becomes one command in a two-entry queue, and the emitter turns it
// into results on res behind an output register, popping the next command only
// once it is through with the last; a command passes from the queue through the
// command hold register into the output register. A text record gives its header
// and then one char per cycle while the sink is ready, read from a 36-byte text
// store RAM; pkt.ready stays low from the transfer that completes a text record
// until its last char is in the output register, because the next value bytes
// would be written into that same store. The command queue filling up is the only
// other cause of backpressure on pkt.

module tlv_display_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	tdcp_in_if.sink     pkt,
	tdcp_out_if.source  res
);

	logic                          push;
	tdcp_pkg::cmd_t                push_cmd;
	logic                          q_not_full;
	logic                          q_not_empty;
	logic                          q_pop;
	tdcp_pkg::cmd_t                q_head;
	logic                          txt_done;
	logic                          ram_we;
	logic [tdcp_pkg::ADDR_W-1:0]   ram_waddr;
	logic [7:0]                    ram_wdata;
	logic                          ram_re;
	logic [tdcp_pkg::ADDR_W-1:0]   ram_raddr;
	logic [7:0]                    ram_rdata;

	tdcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_not_full (q_not_full),
		.txt_done   (txt_done),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	tdcp_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	tdcp_ram #(
		.WIDTH (8),
		.DEPTH (tdcp_pkg::TEXT_MAX)
	) u_text_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tdcp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.txt_done    (txt_done),
		.res         (res)
	);

endmodule

FILE: test/tlv_display_command_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tlv_display_command_parser: drives packets byte by byte and
// checks every result against an in-bench parser model. Depends on tdcp_pkg, tdcp_if and the top level.

module tlv_display_command_parser_tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          LONG_HOLD_CYCLES = 300;
	localparam int unsigned ITEM_COUNT = 100;
	localparam int unsigned IDLE_FROM = 75;

	// Record type codes
	localparam logic [7:0] REC_PROGRESS      = 8'h01;
	localparam logic [7:0] REC_BAR           = 8'h02;
	localparam logic [7:0] REC_PERCENT       = 8'h03;
	localparam logic [7:0] REC_TOP_TEXT      = 8'h04;
	localparam logic [7:0] REC_TOP_COLOUR    = 8'h05;
	localparam logic [7:0] REC_BOTTOM_TEXT   = 8'h06;
	localparam logic [7:0] REC_BOTTOM_COLOUR = 8'h07;

	typedef enum logic [1:0] {
		AWAIT_TYPE,
		AWAIT_LENGTH,
		IN_VALUE
	} parse_phase_t;

	typedef struct {
		logic [tdcp_pkg::KIND_W-1:0]  kind;
		logic [tdcp_pkg::VALUE_W-1:0] value;
		logic [tdcp_pkg::IDX_W-1:0]   char_index;
		logic                         last;
	} display_result_t;

	// Parser model plus the queue of results it still owes
	class display_scoreboard;
		display_result_t pending[$];
		int unsigned     failures;
		parse_phase_t    phase;
		logic [7:0]      rec_type;
		logic [7:0]      rec_len;
		logic [7:0]      bytes_seen;
		logic [23:0]     colour_acc;
		logic [7:0]      text_store [tdcp_pkg::TEXT_MAX];

		function new();
			failures   = 0;
			phase      = AWAIT_TYPE;
			rec_type   = '0;
			rec_len    = '0;
			bytes_seen = '0;
			colour_acc = '0;
		endfunction

		function void push(logic [tdcp_pkg::KIND_W-1:0] kind,
			logic [tdcp_pkg::VALUE_W-1:0] value, logic [tdcp_pkg::IDX_W-1:0] idx);
			display_result_t r;
			r.kind       = kind;
			r.value      = value;
			r.char_index = idx;
			r.last       = 1'b0;
			pending.push_back(r);
		endfunction

		// Turn a finished record into its results
		function void finish_record();
			int cnt;
			case (rec_type)
				REC_PROGRESS: begin
					if (rec_len != 8'd1)
						push(tdcp_pkg::KIND_BAD_LENGTH, tdcp_pkg::VALUE_W'(rec_len), '0);
					else
						push(tdcp_pkg::KIND_PROGRESS, tdcp_pkg::VALUE_W'(colour_acc[7:0]), '0);
				end
				REC_BAR, REC_PERCENT, REC_TOP_COLOUR, REC_BOTTOM_COLOUR: begin
					if (rec_len != 8'd3)
						push(tdcp_pkg::KIND_BAD_LENGTH, tdcp_pkg::VALUE_W'(rec_len), '0);
					else if (rec_type == REC_BAR)
						push(tdcp_pkg::KIND_BAR_COLOUR, colour_acc, '0);
					else if (rec_type == REC_PERCENT)
						push(tdcp_pkg::KIND_PERCENT_COLOUR, colour_acc, '0);
					else if (rec_type == REC_TOP_COLOUR)
						push(tdcp_pkg::KIND_TOP_COLOUR, colour_acc, '0);
					else
						push(tdcp_pkg::KIND_BOTTOM_COLOUR, colour_acc, '0);
				end
				REC_TOP_TEXT, REC_BOTTOM_TEXT: begin
					cnt = (rec_len < tdcp_pkg::TEXT_MAX) ? int'(rec_len) : tdcp_pkg::TEXT_MAX;
					push((rec_type == REC_TOP_TEXT) ? tdcp_pkg::KIND_TOP_HDR :
						tdcp_pkg::KIND_BOTTOM_HDR, tdcp_pkg::VALUE_W'(cnt), '0);
					for (int i = 0; i < cnt; i++)
						push(tdcp_pkg::KIND_TEXT_CHAR, tdcp_pkg::VALUE_W'(text_store[i]),
							tdcp_pkg::IDX_W'(i));
				end
				default: begin
					push(tdcp_pkg::KIND_UNKNOWN_TYPE, tdcp_pkg::VALUE_W'(rec_type), '0);
				end
			endcase
		endfunction

		// One accepted packet byte
		function void note_byte(logic [7:0] b, logic eop);
			int prior_count;
			prior_count = pending.size();
			case (phase)
				AWAIT_LENGTH: begin
					rec_len    = b;
					bytes_seen = '0;
					colour_acc = '0;
					if (b == 8'd0) begin
						phase = AWAIT_TYPE;
						finish_record();
					end else if (eop) begin
						phase = AWAIT_TYPE;
						push(tdcp_pkg::KIND_TRUNCATED, '0, '0);
					end else begin
						phase = IN_VALUE;
					end
				end
				IN_VALUE: begin
					if (bytes_seen < 3)
						colour_acc = {colour_acc[15:0], b};
					if (bytes_seen < tdcp_pkg::TEXT_MAX)
						text_store[bytes_seen[tdcp_pkg::ADDR_W-1:0]] = b;
					bytes_seen = bytes_seen + 8'd1;
					if (bytes_seen >= rec_len) begin
						phase = AWAIT_TYPE;
						finish_record();
					end else if (eop) begin
						phase = AWAIT_TYPE;
						push(tdcp_pkg::KIND_TRUNCATED, tdcp_pkg::VALUE_W'(bytes_seen), '0);
					end
				end
				default: begin
					rec_type = b;
					if (eop) begin
						phase = AWAIT_TYPE;
						push(tdcp_pkg::KIND_DANGLING, 24'd1, '0);
					end else begin
						phase = AWAIT_LENGTH;
					end
				end
			endcase
			if (pending.size() > prior_count)
				pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void check_result(logic [tdcp_pkg::KIND_W-1:0] kind,
			logic [tdcp_pkg::VALUE_W-1:0] value, logic [tdcp_pkg::IDX_W-1:0] idx, logic last);
			display_result_t exp_r;
			if (pending.size() == 0) begin
				$error("unexpected result: kind %0d value 0x%0h char_index %0d last %0b",
					kind, value, idx, last);
				failures++;
				return;
			end
			exp_r = pending.pop_front();
			if (kind !== exp_r.kind) begin
				$error("kind: expected %0d, got %0d", exp_r.kind, kind);
				failures++;
			end
			if (value !== exp_r.value) begin
				$error("value: expected 0x%0h, got 0x%0h", exp_r.value, value);
				failures++;
			end
			if (idx !== exp_r.char_index) begin
				$error("char_index: expected %0d, got %0d", exp_r.char_index, idx);
				failures++;
			end
			if (last !== exp_r.last) begin
				$error("last: expected %0b, got %0b", exp_r.last, last);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tdcp_in_if  pkt_ch ();
	tdcp_out_if res_ch ();

	tlv_display_command_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch)
	);

	display_scoreboard board;
	logic [7:0]        packet_bytes[$];
	bit                idling;
	bit                hold_request;
	int unsigned       bytes_sent;
	int unsigned       cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: check each transfer, then choose ready for the next cycle
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				board.check_result(res_ch.kind, res_ch.value, res_ch.char_index, res_ch.last);
			// Long hold-off, counted here once requested
			if (hold_request && !hold_taken) begin
				hold_left  = LONG_HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (!arst_n) begin
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !(idling && $urandom_range(99) < 38);
			end
		end
	end

	// Offer one byte, with random gaps before it while idling, and wait for its transfer
	task automatic send_byte(input logic [7:0] b, input logic eop);
		while (idling && $urandom_range(99) < 38) begin
			pkt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_ch.valid         <= 1'b1;
		pkt_ch.payload_byte  <= b;
		pkt_ch.end_of_packet <= eop;
		@(posedge clk);
		while (!pkt_ch.ready)
			@(posedge clk);
		board.note_byte(b, eop);
		bytes_sent++;
	endtask

	// End of packet is flagged on the last queued byte
	task automatic send_packet();
		foreach (packet_bytes[i])
			send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
		packet_bytes.delete();
	endtask

	function automatic void add_record(logic [7:0] rtype, int len);
		packet_bytes.push_back(rtype);
		packet_bytes.push_back(len[7:0]);
		repeat (len)
			packet_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Mostly well-formed records, some with bad lengths, unknown types or long text
	function automatic void add_random_record();
		int         pick;
		int         len;
		logic [7:0] rtype;
		pick = $urandom_range(99);
		if (pick < 70) begin
			rtype = 8'($urandom_range(REC_PROGRESS, REC_BOTTOM_COLOUR));
			case (rtype)
				REC_PROGRESS: len = 1;
				REC_TOP_TEXT, REC_BOTTOM_TEXT: begin
					len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
				end
				default: len = 3;
			endcase
		end else if (pick < 82) begin
			rtype = 8'($urandom_range(REC_PROGRESS, REC_BOTTOM_COLOUR));
			len = ($urandom_range(7) == 0) ? $urandom_range(37, 64) : $urandom_range(0, 6);
		end else if (pick < 95) begin
			rtype = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(8, 255));
			len = $urandom_range(0, 5);
		end else begin
			rtype = $urandom_range(1) ? REC_TOP_TEXT : REC_BOTTOM_TEXT;
			len = $urandom_range(tdcp_pkg::TEXT_MAX, 60);
		end
		add_record(rtype, len);
	endfunction

	initial begin
		int pick;
		int cut;
		board        = new();
		idling       = 1'b1;
		hold_request = 1'b0;
		bytes_sent   = 0;
		arst_n       = 1'b0;
		pkt_ch.valid         <= 1'b0;
		pkt_ch.payload_byte  <= '0;
		pkt_ch.end_of_packet <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: progress at full scale, a colour, unknown type 0, bad zero length,
		// empty text, dangling type byte, packet ending on a length byte and inside a value
		packet_bytes = '{REC_PROGRESS, 8'h01, 8'hFF};
		send_packet();
		packet_bytes = '{REC_BAR, 8'h03, 8'h00, 8'hFF, 8'h80};
		send_packet();
		packet_bytes = '{8'h00, 8'h02, 8'hAA, 8'h55};
		send_packet();
		packet_bytes = '{REC_PROGRESS, 8'h00, REC_TOP_TEXT, 8'h00};
		send_packet();
		packet_bytes = '{8'hFF};
		send_packet();
		packet_bytes = '{REC_BOTTOM_TEXT, 8'h05};
		send_packet();
		packet_bytes = '{REC_PERCENT, 8'h03, 8'h12};
		send_packet();

		// Long sink stall with the sender streaming: text longer than the store first
		idling       = 1'b0;
		hold_request = 1'b1;
		add_record(REC_TOP_TEXT, tdcp_pkg::TEXT_MAX + 4);
		send_packet();

		// Random packets
		while (bytes_sent < ITEM_COUNT) begin
			idling = bytes_sent >= IDLE_FROM;
			repeat ($urandom_range(1, 3))
				add_random_record();
			pick = $urandom_range(99);
			if (pick < 12) begin
				cut = $urandom_range(1, packet_bytes.size());
				while (packet_bytes.size() > cut)
					void'(packet_bytes.pop_back());
			end else if (pick < 17) begin
				packet_bytes.delete();
				repeat ($urandom_range(1, 8))
					packet_bytes.push_back(8'($urandom_range(0, 255)));
			end
			send_packet();
		end
		pkt_ch.valid <= 1'b0;

		// Drain, then give stray results a chance to show
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
